/* src/dcd_pkg.sv */
`default_nettype none

package dcd_pkg;

  // Fixed field widths
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned RADIUS_BITS = 12;
  localparam int unsigned REL_BITS = 8;
  localparam int unsigned PROG_BITS = 9;
  localparam int unsigned QUOT_BITS = 8;
  localparam int unsigned SQ_BITS = 2 * COORD_BITS;
  localparam int unsigned ACC_BITS = SQ_BITS + 1;
  localparam int unsigned DIV_CNT_BITS = $clog2(QUOT_BITS);

  localparam int unsigned IN_DATA_BITS = 24;
  localparam int unsigned OUT_DATA_BITS = 40;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Constants of the behavior
  localparam logic [REL_BITS-1:0] RELEASE_TICKS = REL_BITS'(150);
  localparam logic [TIMER_BITS-1:0] DWELL_MIN = TIMER_BITS'(100);
  localparam logic [TIMER_BITS-1:0] DWELL_RESET = TIMER_BITS'(1000);
  localparam logic [RADIUS_BITS-1:0] RADIUS_MIN = RADIUS_BITS'(1);
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(30);
  localparam logic [PROG_BITS-1:0] PROG_FULL = PROG_BITS'(256);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(QUOT_BITS - 1);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DWELL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 2'd2;

  // Item kinds
  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SQ_DX,
    ST_SQ_DY,
    ST_SQ_R,
    ST_CMP,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;   // latch the incoming item
    logic apply;     // tick / first move / clicked handling
    logic sq_dx;     // acc <= dx^2
    logic sq_dy;     // sq <= dy^2
    logic sq_r;      // acc <= acc + sq, sq <= r^2
    logic cmp;       // recentre when acc > sq
    logic prep;      // set up progress
    logic div_step;  // one quotient bit
    logic load_out;  // fill output register
  } dcd_cmd_t;

  typedef struct packed {
    logic need_dist;    // tracked move: distance test required
    logic div_needed;   // active and dwell not yet reached
    logic out_free;     // output register can take a new item
  } dcd_sts_t;

endpackage

`default_nettype wire

/* src/dcd_ctrl.sv */
`default_nettype none

module dcd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dcd_pkg::dcd_sts_t sts_i,
  output dcd_pkg::dcd_cmd_t      cmd_o
);

  dcd_pkg::ctrl_state_e state_q, state_d;
  logic [dcd_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dcd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = dcd_pkg::ST_APPLY;
        end
      end
      dcd_pkg::ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = sts_i.need_dist ? dcd_pkg::ST_SQ_DX : dcd_pkg::ST_PREP;
      end
      dcd_pkg::ST_SQ_DX: begin
        cmd_o.sq_dx = 1'b1;
        state_d = dcd_pkg::ST_SQ_DY;
      end
      dcd_pkg::ST_SQ_DY: begin
        cmd_o.sq_dy = 1'b1;
        state_d = dcd_pkg::ST_SQ_R;
      end
      dcd_pkg::ST_SQ_R: begin
        cmd_o.sq_r = 1'b1;
        state_d = dcd_pkg::ST_CMP;
      end
      dcd_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d = dcd_pkg::ST_PREP;
      end
      dcd_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        state_d = sts_i.div_needed ? dcd_pkg::ST_DIV : dcd_pkg::ST_OUT;
      end
      dcd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dcd_pkg::DIV_LAST) begin
          state_d = dcd_pkg::ST_OUT;
        end
      end
      dcd_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = dcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/dcd_dp.sv */
`default_nettype none

module dcd_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // item in
  input  wire logic                               item_cmd_i,
  input  wire logic [dcd_pkg::IN_DATA_BITS-1:0]   item_data_i,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [dcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [dcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // result out
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [dcd_pkg::OUT_DATA_BITS-1:0]       out_data_o,
  // controller link
  input  wire dcd_pkg::dcd_cmd_t                  cmd_i,
  output dcd_pkg::dcd_sts_t                       sts_o
);

  localparam int unsigned CB = dcd_pkg::COORD_BITS;
  localparam int unsigned TB = dcd_pkg::TIMER_BITS;

  // latched item
  logic          kind_q;
  logic [CB-1:0] px_q, py_q;

  // configuration (stored as effective values)
  logic                            enable_q;
  logic [TB-1:0]                   dwell_q;
  logic [dcd_pkg::RADIUS_BITS-1:0] radius_q;

  // detector state
  logic                          tracking_q, clicked_q;
  logic [CB-1:0]                 anchor_x_q, anchor_y_q;
  logic [TB-1:0]                 elapsed_q;
  logic [dcd_pkg::REL_BITS-1:0]  rel_cnt_q;
  logic                          click_q, unclick_q;

  // arithmetic scratch
  logic [dcd_pkg::ACC_BITS-1:0]  acc_q;
  logic [dcd_pkg::SQ_BITS-1:0]   sq_q;
  logic [TB-1:0]                 rem_q;
  logic [dcd_pkg::PROG_BITS-1:0] prog_q;

  logic                             out_valid_q;
  logic [dcd_pkg::OUT_DATA_BITS-1:0] out_data_q;

  logic [CB-1:0]                 dx, dy, mul_op;
  logic [dcd_pkg::SQ_BITS-1:0]   product;
  logic [TB-1:0]                 elapsed_inc;
  logic [dcd_pkg::REL_BITS-1:0]  rel_inc;
  logic                          active;
  logic [TB:0]                   rem_sh;
  logic                          q_bit;
  logic [dcd_pkg::CFG_DATA_BITS-1:0] cfg_dwell;
  logic [dcd_pkg::RADIUS_BITS-1:0]   cfg_radius;

  assign dx = (px_q >= anchor_x_q) ? px_q - anchor_x_q : anchor_x_q - px_q;
  assign dy = (py_q >= anchor_y_q) ? py_q - anchor_y_q : anchor_y_q - py_q;

  // one shared squarer
  always_comb begin
    if (cmd_i.sq_dx) begin
      mul_op = dx;
    end else if (cmd_i.sq_dy) begin
      mul_op = dy;
    end else begin
      mul_op = CB'(radius_q);
    end
  end
  assign product = {{CB{1'b0}}, mul_op} * {{CB{1'b0}}, mul_op};

  assign elapsed_inc = (elapsed_q == {TB{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
  assign rel_inc     = rel_cnt_q + 1'b1;
  assign active      = enable_q & tracking_q & ~clicked_q;

  // restoring division step: progress = floor(elapsed * 256 / dwell)
  assign rem_sh = {rem_q, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, dwell_q});

  assign cfg_dwell  = (cfg_data_i < dcd_pkg::DWELL_MIN) ? dcd_pkg::DWELL_MIN : cfg_data_i;
  assign cfg_radius = (cfg_data_i[dcd_pkg::RADIUS_BITS-1:0] == '0) ?
                      dcd_pkg::RADIUS_MIN : cfg_data_i[dcd_pkg::RADIUS_BITS-1:0];

  assign sts_o.need_dist  = enable_q & (kind_q == dcd_pkg::CMD_MOVE) & ~clicked_q & tracking_q;
  assign sts_o.div_needed = active & (elapsed_q < dwell_q);
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      dwell_q     <= dcd_pkg::DWELL_RESET;
      radius_q    <= dcd_pkg::RADIUS_RESET;
      tracking_q  <= 1'b0;
      clicked_q   <= 1'b0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      elapsed_q   <= '0;
      rel_cnt_q   <= '0;
      click_q     <= 1'b0;
      unclick_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        click_q   <= 1'b0;
        unclick_q <= 1'b0;
        if (enable_q) begin
          if (kind_q == dcd_pkg::CMD_MOVE) begin
            if (!clicked_q && !tracking_q) begin
              tracking_q <= 1'b1;
              anchor_x_q <= px_q;
              anchor_y_q <= py_q;
              elapsed_q  <= '0;
            end
          end else if (clicked_q) begin
            rel_cnt_q <= rel_inc;
            if (rel_inc >= dcd_pkg::RELEASE_TICKS) begin
              unclick_q  <= 1'b1;
              tracking_q <= 1'b0;
              clicked_q  <= 1'b0;
              elapsed_q  <= '0;
              rel_cnt_q  <= '0;
            end
          end else if (tracking_q) begin
            elapsed_q <= elapsed_inc;
            if (elapsed_inc >= dwell_q) begin
              clicked_q <= 1'b1;
              click_q   <= 1'b1;
              rel_cnt_q <= '0;
            end
          end
        end
      end

      if (cmd_i.cmp && (acc_q > {1'b0, sq_q})) begin
        anchor_x_q <= px_q;
        anchor_y_q <= py_q;
        elapsed_q  <= '0;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          dcd_pkg::REG_ENABLE: begin
            enable_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              tracking_q <= 1'b0;
              clicked_q  <= 1'b0;
              elapsed_q  <= '0;
              rel_cnt_q  <= '0;
            end
          end
          dcd_pkg::REG_DWELL:  dwell_q  <= cfg_dwell;
          dcd_pkg::REG_RADIUS: radius_q <= cfg_radius;
          default: ;
        endcase
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= item_cmd_i;
      px_q   <= item_data_i[CB-1:0];
      py_q   <= item_data_i[2*CB-1:CB];
    end
    if (cmd_i.sq_dx) begin
      acc_q <= {1'b0, product};
    end
    if (cmd_i.sq_dy) begin
      sq_q <= product;
    end
    if (cmd_i.sq_r) begin
      acc_q <= acc_q + {1'b0, sq_q};
      sq_q  <= product;
    end
    if (cmd_i.prep) begin
      rem_q <= elapsed_q;
      if (!active) begin
        prog_q <= '0;
      end else if (elapsed_q >= dwell_q) begin
        prog_q <= dcd_pkg::PROG_FULL;
      end else begin
        prog_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? TB'(rem_sh - {1'b0, dwell_q}) : rem_sh[TB-1:0];
      prog_q <= {prog_q[dcd_pkg::PROG_BITS-2:0], q_bit};
    end
    if (cmd_i.load_out) begin
      out_data_q <= {4'b0000, anchor_y_q, anchor_x_q, prog_q, active, unclick_q, click_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* src/dwell_click_detector.sv */
`default_nettype none

// Dwell click detector. Each item in is either a pointer move sample
// (s_axis_tuser = 0, position in s_axis_tdata) or a one millisecond tick
// (s_axis_tuser = 1), and each item gives exactly one result item out.
// The first move while enabled and idle starts tracking and sets the dwell
// centre; a later move farther than the radius from the centre re-centres
// and restarts the dwell. Ticks count dwell time; reaching dwell_ms raises
// click, and 150 ticks later unclick is raised and the detector goes idle.
// progress is floor(elapsed * 256 / dwell) capped at 256, zero when not active.
// One item at a time. A tick or untracked move passes through apply,
// progress set-up, the restoring divider for progress and the output
// state before it is loaded into the output register; a tracked move also
// passes through the single shared squarer, used in turn for dx^2, dy^2 and
// radius^2, and the distance compare before the progress set-up. When the
// detector is not active or the dwell is already complete the divider is
// skipped. A new item is accepted as soon as the previous one has been
// placed in the output register, even if that result is still waiting.
// Configuration writes are taken every cycle (cfg_ready_o is tied high) and
// must be issued only while the block is idle. dwell_ms below 100 acts as
// 100, radius 0 acts as 1; register index 3 is ignored.
module dwell_click_detector (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input items
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dcd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // pos_x[11:0], pos_y[23:12]
  input  wire logic                               s_axis_tuser,  // cmd
  // result items
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // click[0], unclick[1], active[2], progress[11:3], centre_x[23:12],
  // centre_y[35:24], zero[39:36]
  output logic [dcd_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
  // configuration writes
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [dcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  dcd_pkg::dcd_cmd_t cmd;
  dcd_pkg::dcd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer: walks each item through apply, distance test and division
  dcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // state, squarer, divider and output register
  dcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_cmd_i  (s_axis_tuser),
    .item_data_i (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // click and unclick never come on the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("click and unclick together");

  // progress is zero whenever the detector is not active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[11:3] == '0))
    else $error("progress while inactive");

  // a click ends the active phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[2])
    else $error("active after click");

  // progress never exceeds one in Q1.8
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:3] <= dcd_pkg::PROG_FULL))
    else $error("progress out of range");

endmodule

`default_nettype wire

/* tb/sv/tb_dwell_click_detector.sv */
module tb_dwell_click_detector;
  import dcd_pkg::*;

  // Register index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  // Watchdog: cycles without any handshake before the run is declared hung.
  // The slowest legal gap between acceptances is a sender gap, a tracked
  // move and a receiver stall together, so the limit is ample.
  localparam int unsigned STALL_LIMIT = 2000;
  // Quiet cycles after the last result, well past the slowest item.
  localparam int unsigned END_SETTLE = 32;

  // One pointer item: a move sample or a millisecond tick.
  typedef struct {
    logic                  cmd;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } pointer_item_t;

  // Result layout on m_axis_tdata, last field in the lowest bits.
  typedef struct packed {
    logic [COORD_BITS-1:0] centre_y;
    logic [COORD_BITS-1:0] centre_x;
    logic [PROG_BITS-1:0]  progress;
    logic                  active;
    logic                  unclick;
    logic                  click;
  } dwell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // pos_x[11:0], pos_y[23:12]
  logic                     s_axis_tuser = 1'b0; // cmd
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // click[0], unclick[1], active[2], progress[11:3], centre_x[23:12], centre_y[35:24]
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  dwell_click_detector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers as written, plus the detector's own state.
  // ---------------------------------------------------------------------------
  logic                  enable_r   = 1'b0;
  logic [TIMER_BITS-1:0] dwell_r    = DWELL_RESET;
  logic [RADIUS_BITS-1:0] radius_r  = RADIUS_RESET;
  logic                  tracking_q = 1'b0;
  logic                  clicked_q  = 1'b0;
  logic [COORD_BITS-1:0] centre_x_q = '0;
  logic [COORD_BITS-1:0] centre_y_q = '0;
  logic [TIMER_BITS-1:0] dwell_count = '0;
  logic [REL_BITS-1:0]   release_ticks = '0;

  pointer_item_t pending_items[$];      // items waiting for the driver
  dwell_result_t expected_results[$];   // predicted results, oldest first
  int unsigned   queued_count = 0;
  int unsigned   accepted_count = 0;
  int unsigned   error_count = 0;

  bit sender_idle_en = 1'b0;
  bit receiver_idle_en = 1'b0;

  // Register write as the detector sees it. Dropping enable wipes all
  // tracking and click state but keeps the centre.
  function automatic void apply_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_ENABLE: begin
        enable_r = data[0];
        if (!data[0]) begin
          tracking_q    = 1'b0;
          clicked_q     = 1'b0;
          dwell_count   = '0;
          release_ticks = '0;
        end
      end
      REG_DWELL:  dwell_r = data[TIMER_BITS-1:0];
      REG_RADIUS: radius_r = data[RADIUS_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Apply one item to the predicted state and return the result it yields.
  function automatic dwell_result_t advance_dwell(logic cmd, logic [COORD_BITS-1:0] px,
                                                  logic [COORD_BITS-1:0] py);
    dwell_result_t         res;
    logic [TIMER_BITS-1:0] dwell_eff;
    logic [RADIUS_BITS-1:0] radius_eff;
    longint unsigned       dx, dy, dist_sq, radius_sq;
    res        = '0;
    dwell_eff  = (dwell_r < DWELL_MIN) ? DWELL_MIN : dwell_r;
    radius_eff = (radius_r < RADIUS_MIN) ? RADIUS_MIN : radius_r;
    if (enable_r) begin
      if (cmd == CMD_MOVE) begin
        // moves after the click are ignored until the unclick
        if (!clicked_q) begin
          dx = (px >= centre_x_q) ? px - centre_x_q : centre_x_q - px;
          dy = (py >= centre_y_q) ? py - centre_y_q : centre_y_q - py;
          dist_sq   = dx * dx + dy * dy;
          radius_sq = longint'(radius_eff) * radius_eff;
          // first move starts tracking; a move beyond the radius re-centres
          if (!tracking_q || dist_sq > radius_sq) begin
            tracking_q  = 1'b1;
            centre_x_q  = px;
            centre_y_q  = py;
            dwell_count = '0;
          end
        end
      end else if (clicked_q) begin
        release_ticks++;
        if (release_ticks >= RELEASE_TICKS) begin
          res.unclick   = 1'b1;
          tracking_q    = 1'b0;
          clicked_q     = 1'b0;
          dwell_count   = '0;
          release_ticks = '0;
        end
      end else if (tracking_q) begin
        if (dwell_count != '1) dwell_count++;   // saturates
        // also fires at once when dwell was lowered below the count
        if (dwell_count >= dwell_eff) begin
          clicked_q     = 1'b1;
          res.click     = 1'b1;
          release_ticks = '0;
        end
      end
    end
    res.active = enable_r && tracking_q && !clicked_q;
    if (res.active) begin
      if (dwell_count >= dwell_eff) res.progress = PROG_FULL;
      else res.progress = PROG_BITS'((int'(dwell_count) * 256) / int'(dwell_eff));
    end
    res.centre_x = centre_x_q;
    res.centre_y = centre_y_q;
    return res;
  endfunction

  // Predictor follows every accepted register write and input item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg_write(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(advance_dwell(s_axis_tuser, s_axis_tdata[11:0],
                                                 s_axis_tdata[23:12]));
        accepted_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, holds while stalled, random gaps after items.
  // ---------------------------------------------------------------------------
  pointer_item_t drive_item;
  int unsigned   send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_item.pos_y, drive_item.pos_x};
        s_axis_tuser  <= drive_item.cmd;
        if (sender_idle_en && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, and each result checked against the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  dwell_result_t seen_result;
  dwell_result_t want_result;
  int unsigned   ready_hold = 0;

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result = dwell_result_t'(m_axis_tdata[$bits(dwell_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          $error("result item with none pending: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("click", want_result.click, seen_result.click);
          check_field("unclick", want_result.unclick, seen_result.unclick);
          check_field("active", want_result.active, seen_result.active);
          check_field("progress", want_result.progress, seen_result.progress);
          check_field("centre_x", want_result.centre_x, seen_result.centre_x);
          check_field("centre_y", want_result.centre_y, seen_result.centre_y);
        end
      end
      if (ready_hold != 0) begin
        ready_hold--;
        m_axis_tready <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(0, 9);   // random-length burst of stalled cycles
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic cmd, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    pointer_item_t it;
    it.cmd   = cmd;
    it.pos_x = x;
    it.pos_y = y;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Sender pause: everything sent has been accepted and answered.
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Single register write; call only with the detector idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] jitter(int unsigned c, int unsigned spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return COORD_BITS'(v);
  endfunction

  // A hovering pointer: mostly ticks, small moves around (cx, cy), and a rare
  // jump anywhere on screen that re-centres the dwell.
  task automatic queue_dwell_run(input int unsigned n, input int unsigned cx,
                                 input int unsigned cy, input int unsigned spread);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 199);
      if (pick < 170) queue_item(CMD_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom));
      else if (pick < 199) queue_item(CMD_MOVE, jitter(cx, spread), jitter(cy, spread));
      else queue_item(CMD_MOVE, COORD_BITS'($urandom_range(0, 4095)),
                      COORD_BITS'($urandom_range(0, 4095)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;

    // Disabled after reset: nothing moves, centre stays at zero.
    queue_item(CMD_MOVE, 12'hFFF, 12'h000);
    queue_item(CMD_TICK, 12'h000, 12'hFFF);
    queue_item(CMD_MOVE, 12'h000, 12'hFFF);
    wait_drained();

    write_reg(REG_UNUSED, 16'hFFFF);   // dropped
    write_reg(REG_RADIUS, 16'd0);      // acts as radius 1
    write_reg(REG_DWELL, 16'd0);       // acts as 100 ticks
    write_reg(REG_ENABLE, 16'hFFFF);   // only bit 0 counts

    // Tick while idle, then radius-1 boundary moves and screen extremes.
    queue_item(CMD_TICK, 12'hFFF, 12'hFFF);
    queue_item(CMD_MOVE, 12'd0, 12'd0);          // starts tracking
    queue_item(CMD_MOVE, 12'd1, 12'd0);          // exactly on the radius: stays
    queue_item(CMD_MOVE, 12'd1, 12'd1);          // outside: re-centre
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_item(CMD_MOVE, 12'd1, 12'd2);          // on the radius again
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_item(CMD_MOVE, 12'hFFF, 12'hFFF);      // far corner
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_item(CMD_MOVE, 12'hFFF, 12'hFFE);
    queue_item(CMD_MOVE, 12'hFFE, 12'hFFE);      // diagonal: re-centre
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_item(CMD_MOVE, 12'h000, 12'hFFF);
    queue_item(CMD_TICK, 12'hABC, 12'h543);
    wait_drained();

    // Short dwell, medium radius: full click / unclick cycles with moves
    // inside the radius, including moves during the release wait.
    write_reg(REG_DWELL, 16'd100);
    write_reg(REG_RADIUS, 16'd30);
    for (int k = 0; k < 3; k++) begin
      queue_dwell_run(230, $urandom_range(0, 4095), $urandom_range(0, 4095), 10);
      if (k == 0 || $urandom_range(0, 1) == 1) wait_drained();   // sender pause
    end
    wait_drained();

    // Dwell lowered below the elapsed count: the next tick clicks.
    write_reg(REG_ENABLE, 16'h0000);
    write_reg(REG_ENABLE, 16'h0001);
    write_reg(REG_DWELL, 16'd1000);
    write_reg(REG_RADIUS, 16'hFFFF);   // radius 4095
    receiver_idle_en = 1'b0;
    queue_item(CMD_MOVE, 12'd2048, 12'd2048);
    repeat (120) queue_item(CMD_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom));
    wait_drained();
    write_reg(REG_DWELL, 16'd7);       // below the minimum too
    queue_dwell_run(200, 2048, 2048, 300);
    wait_drained();

    // Disable while clicked cancels the pending unclick; centre is kept.
    receiver_idle_en = 1'b1;
    write_reg(REG_DWELL, 16'd100);
    write_reg(REG_RADIUS, 16'd1);
    queue_dwell_run(180, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
    wait_drained();
    write_reg(REG_ENABLE, 16'hFFFE);
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_item(CMD_MOVE, 12'h123, 12'h456);
    queue_item(CMD_TICK, 12'd0, 12'd0);
    wait_drained();
    write_reg(REG_ENABLE, 16'h0001);
    queue_item(CMD_TICK, 12'd0, 12'd0);
    queue_dwell_run(120, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
    wait_drained();

    // Noise: longest dwell, small random radius, any item anywhere.
    write_reg(REG_DWELL, 16'hFFFF);
    write_reg(REG_RADIUS, 16'($urandom_range(0, 600)));
    repeat (200)
      queue_item(1'($urandom_range(0, 1)), COORD_BITS'($urandom_range(0, 4095)),
                 COORD_BITS'($urandom_range(0, 4095)));
    wait_drained();

    // Last stretch with no idling on either side.
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    r = $urandom_range(1, 60);
    write_reg(REG_DWELL, 16'($urandom_range(100, 160)));
    write_reg(REG_RADIUS, 16'(r));
    queue_dwell_run(200, $urandom_range(0, 4095), $urandom_range(0, 4095), r / 3);
    wait_drained();

    repeat (END_SETTLE) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* dwell_click_detector.f */
src/dcd_pkg.sv
src/dcd_ctrl.sv
src/dcd_dp.sv
src/dwell_click_detector.sv
tb/sv/tb_dwell_click_detector.sv
